>>> src/fbc_pkg.sv
package fbc_pkg;

   localparam int StepsW = 14;
   localparam int CntW   = 32;
   localparam int DirW   = 2;
   localparam int OpW    = 2;
   localparam int StepW  = 15;
   localparam int AddrW  = 4;
   localparam int DataW  = 32;
   localparam int ReqDataW = 24;
   localparam int RspDataW = 208;

   localparam logic [OpW-1:0] OP_QUERY  = 2'd0;
   localparam logic [OpW-1:0] OP_REPORT = 2'd1;
   localparam logic [OpW-1:0] OP_RECORD = 2'd2;

   localparam logic [DirW-1:0] DIR_NONE    = 2'd0;
   localparam logic [DirW-1:0] DIR_INWARD  = 2'd1;
   localparam logic [DirW-1:0] DIR_OUTWARD = 2'd2;

   localparam logic [1:0] MODE_SIMPLE   = 2'd0;
   localparam logic [1:0] MODE_ADAPTIVE = 2'd1;
   localparam logic [1:0] MODE_DYNAMIC  = 2'd2;

   localparam logic [1:0] REG_ENABLE    = 2'd0;
   localparam logic [1:0] REG_STEPS     = 2'd1;
   localparam logic [1:0] REG_PREFERRED = 2'd2;
   localparam logic [1:0] REG_MODE      = 2'd3;

   localparam logic [StepsW-1:0] STEPS_MAX = '1;
   localparam logic [CntW-1:0]   CNT_MAX   = '1;

   typedef struct packed {
      logic              enable;
      logic [StepsW-1:0] steps;
      logic [DirW-1:0]   preferred;
      logic [1:0]        mode;
   } cfg_type;

   typedef struct packed {
      logic [OpW-1:0]          op;
      logic [DirW-1:0]         move_direction;
      logic signed [StepW-1:0] step_count;
      logic                    move_ok;
   } req_type;

   typedef struct packed {
      logic [DirW-1:0]        last_direction;
      logic signed [CntW-1:0] position;
      logic [CntW-1:0]        total;
      logic [CntW-1:0]        success;
      logic [CntW-1:0]        abs_sum;
      logic [CntW-1:0]        inward;
      logic [CntW-1:0]        outward;
   } stats_type;

endpackage

>>> src/fbc_query.sv
module fbc_query
   import fbc_pkg::*;
(
   input  cfg_type           cfg,
   input  stats_type         stats,
   input  logic [DirW-1:0]   move_direction,
   output logic [StepsW-1:0] comp_steps
);

   logic [29:0]       prod;
   logic [10:0]       quot;
   logic [StepsW-1:0] tenq;
   logic [StepsW-1:0] down;
   logic [StepsW:0]   up;
   logic [StepsW-1:0] up_sat;
   logic [CntW+4:0]   succ20;
   logic [CntW+4:0]   tot19;
   logic [CntW+4:0]   tot17;
   logic              reversal;

   // Division by ten through a reciprocal multiply, exact for the 14-bit step count.
   assign prod   = 30'(cfg.steps) * 30'd52429;
   assign quot   = prod[29:19];
   assign tenq   = StepsW'({quot, 3'b000}) + StepsW'({quot, 1'b0});
   assign down   = cfg.steps - StepsW'(quot) - StepsW'(cfg.steps != tenq);
   assign up     = {1'b0, cfg.steps} + (StepsW+1)'(quot);
   assign up_sat = up[StepsW] ? STEPS_MAX : up[StepsW-1:0];

   assign succ20 = {1'b0, stats.success, 4'b0000} + {3'b000, stats.success, 2'b00};
   assign tot19  = {1'b0, stats.total, 4'b0000} + {4'b0000, stats.total, 1'b0}
                   + {5'b00000, stats.total};
   assign tot17  = {1'b0, stats.total, 4'b0000} + {5'b00000, stats.total};

   assign reversal = (stats.last_direction != DIR_NONE) && (move_direction != DIR_NONE)
                     && (stats.last_direction != move_direction);

   always_comb begin
      comp_steps = '0;
      if (cfg.enable && (cfg.steps != '0) && reversal) begin
         unique case (cfg.mode)
            MODE_SIMPLE: begin
               if ((cfg.preferred == DIR_NONE) || (cfg.preferred == move_direction)) begin
                  comp_steps = cfg.steps;
               end
            end
            MODE_ADAPTIVE: begin
               priority if (stats.total == '0) begin
                  comp_steps = cfg.steps;
               end else if (succ20 > tot19) begin
                  comp_steps = down;
               end else if (tot17 > succ20) begin
                  comp_steps = up_sat;
               end else begin
                  comp_steps = cfg.steps;
               end
            end
            MODE_DYNAMIC: begin
               comp_steps = cfg.steps;
            end
            default: begin
               comp_steps = '0;
            end
         endcase
      end
   end

endmodule

>>> src/fbc_stats.sv
module fbc_stats
   import fbc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  req_type   req,
   input  logic      enable,
   output stats_type stats_cur,
   output stats_type stats_nxt,
   output logic      applied
);

   stats_type              stats_ff;
   stats_type              stats_in;
   logic [StepW-1:0]       mag;
   logic [CntW:0]          abs_sum_wide;
   logic signed [CntW:0]   pos_wide;
   logic                   do_report;

   function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
      return (v == CNT_MAX) ? v : v + CntW'(1);
   endfunction

   assign mag          = req.step_count[StepW-1] ? StepW'(-req.step_count)
                                                 : StepW'(req.step_count);
   assign abs_sum_wide = {1'b0, stats_ff.abs_sum} + (CntW+1)'(mag);
   assign pos_wide     = (CntW+1)'(stats_ff.position) + (CntW+1)'(req.step_count);
   assign do_report    = (req.op == OP_REPORT) && enable && (req.step_count != '0)
                         && req.move_ok;

   always_comb begin
      stats_in = stats_ff;
      if (do_report) begin
         stats_in.total   = sat_inc(stats_ff.total);
         stats_in.success = sat_inc(stats_ff.success);
         stats_in.abs_sum = abs_sum_wide[CntW] ? CNT_MAX : abs_sum_wide[CntW-1:0];
         if (req.move_direction == DIR_INWARD) begin
            stats_in.inward = sat_inc(stats_ff.inward);
         end
         if (req.move_direction == DIR_OUTWARD) begin
            stats_in.outward = sat_inc(stats_ff.outward);
         end
         if (pos_wide[CntW] != pos_wide[CntW-1]) begin
            stats_in.position = pos_wide[CntW] ? {1'b1, {(CntW-1){1'b0}}}
                                               : {1'b0, {(CntW-1){1'b1}}};
         end else begin
            stats_in.position = pos_wide[CntW-1:0];
         end
      end
      if (req.op == OP_RECORD) begin
         stats_in.last_direction = req.move_direction;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stats_ff <= '0;
      end else if (advance) begin
         stats_ff <= stats_in;
      end
   end

   assign stats_cur = stats_ff;
   assign stats_nxt = stats_in;
   assign applied   = do_report;

endmodule

>>> src/focuser_backlash_compensator_unit.sv
// An accepted request enters an input register and its result a result register
// on the rsp side, holding the sides apart; all work is in the single stage between.
// Throughput: one request per cycle unless rsp_tready stalls the result register.
// Reset: synchronous, active high; clears the configuration registers, the
// direction and statistics counters, and both valid flags.
module focuser_backlash_compensator_unit
   import fbc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // move_direction[1:0], step_count[16:2], move_ok[17], zero fill
   input  logic [ReqDataW-1:0] req_tdata,
   // op[1:0]
   input  logic [OpW-1:0]      req_tuser,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // comp_steps[13:0], position_sum[45:14], total_count[77:46],
   // success_count[109:78], steps_sum[141:110], inward_count[173:142],
   // outward_count[205:174], zero fill
   output logic [RspDataW-1:0] rsp_tdata,
   // applied[0]
   output logic                rsp_tuser,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [AddrW-1:0]    csr_paddr,
   input  logic [DataW-1:0]    csr_pwdata,
   output logic [DataW-1:0]    csr_prdata,
   output logic                csr_pready
);

   cfg_type           cfg_ff;
   cfg_type           cfg_in;
   logic              in_vld_ff;
   req_type           in_req_ff;
   logic              out_vld_ff;
   logic              out_vld_in;
   logic [RspDataW-1:0] out_data_ff;
   logic [RspDataW-1:0] out_data_in;
   logic              out_user_ff;
   logic              advance;
   logic              csr_write;
   logic [1:0]        reg_index;
   stats_type         stats_cur;
   stats_type         stats_nxt;
   logic              applied;
   logic [StepsW-1:0] query_steps;
   logic [StepsW-1:0] comp_steps;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index  = csr_paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (reg_index)
            REG_ENABLE:    cfg_in.enable    = csr_pwdata[0];
            REG_STEPS:     cfg_in.steps     = csr_pwdata[StepsW-1:0];
            REG_PREFERRED: cfg_in.preferred = csr_pwdata[DirW-1:0];
            REG_MODE:      cfg_in.mode      = csr_pwdata[1:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_ENABLE:    csr_prdata = DataW'(cfg_ff.enable);
         REG_STEPS:     csr_prdata = DataW'(cfg_ff.steps);
         REG_PREFERRED: csr_prdata = DataW'(cfg_ff.preferred);
         REG_MODE:      csr_prdata = DataW'(cfg_ff.mode);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign advance    = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_req_ff.op             <= req_tuser;
         in_req_ff.move_direction <= req_tdata[1:0];
         in_req_ff.step_count     <= req_tdata[16:2];
         in_req_ff.move_ok        <= req_tdata[17];
      end
   end

   fbc_stats u_stats (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .req       (in_req_ff),
      .enable    (cfg_ff.enable),
      .stats_cur (stats_cur),
      .stats_nxt (stats_nxt),
      .applied   (applied)
   );

   fbc_query u_query (
      .cfg            (cfg_ff),
      .stats          (stats_cur),
      .move_direction (in_req_ff.move_direction),
      .comp_steps     (query_steps)
   );

   assign comp_steps = (in_req_ff.op == OP_QUERY) ? query_steps : '0;

   assign out_data_in = {2'b00, stats_nxt.outward, stats_nxt.inward, stats_nxt.abs_sum,
                         stats_nxt.success, stats_nxt.total, stats_nxt.position,
                         comp_steps};
   assign out_vld_in  = advance || (out_vld_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
         out_user_ff <= applied;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

endmodule
